[design/dbs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the differential backlog scheduler.
// No dependencies.
package dbs_pkg;

  localparam int STORE_DEPTH_DEF = 64;
  localparam int NODE_COUNT_DEF  = 256;

  localparam int TAG_W    = 16;
  localparam int ADDR_W   = 8;
  localparam int CNT_W    = 7;
  localparam int STATUS_W = 3;

  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(50);

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 3'd0,
    ST_OVER_LIMIT = 3'd1,
    ST_STORE_FULL = 3'd2,
    ST_DEQUEUED = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DEQUEUE = 1'b1;

  // One queued packet.
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [ADDR_W-1:0] dest;
    logic              hop_valid;
    logic [ADDR_W-1:0] hop;
  } entry_t;

  // Write request to the count table.
  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] data;
  } cnt_wr_t;

endpackage

[design/dbs_if.sv]
`timescale 1ns / 1ps
// Channel interfaces: request, response and limit register write.
// Depends on dbs_pkg.
interface dbs_req_if import dbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [TAG_W-1:0]  packet_tag;
  logic [ADDR_W-1:0] dest_addr;
  logic [ADDR_W-1:0] hop_addr;
  logic              hop_valid;
  modport source (output valid, action, packet_tag, dest_addr, hop_addr, hop_valid,
                  input ready);
  modport sink (input valid, action, packet_tag, dest_addr, hop_addr, hop_valid,
                output ready);
endinterface

interface dbs_rsp_if import dbs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TAG_W-1:0]    out_tag;
  logic [ADDR_W-1:0]   out_dest;
  logic [CNT_W-1:0]    out_gap;
  modport source (output valid, status, out_tag, out_dest, out_gap, input ready);
  modport sink (input valid, status, out_tag, out_dest, out_gap, output ready);
endinterface

interface dbs_cfg_if import dbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] per_dest_limit;
  modport source (output valid, per_dest_limit, input ready);
  modport sink (input valid, per_dest_limit, output ready);
endinterface

[design/dbs_cell.sv]
`timescale 1ns / 1ps
// One store cell: holds a packet entry, loads a new one or takes its neighbor's.
// Depends on dbs_pkg.
module dbs_cell import dbs_pkg::*; (
  input  logic   clk,
  input  logic   load,
  input  logic   move,
  input  entry_t load_entry,
  input  entry_t nbr_entry,
  output entry_t entry
);

  always_ff @(posedge clk) begin
    if (load) begin
      entry <= load_entry;
    end else if (move) begin
      entry <= nbr_entry;
    end
  end

endmodule

[design/dbs_count_mem.sv]
`timescale 1ns / 1ps
// Per-node count table: one write port, two registered read ports.
// Depends on dbs_pkg.
module dbs_count_mem import dbs_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int NW = $clog2(NODE_COUNT)
) (
  input  logic             clk,
  input  cnt_wr_t          wr,
  input  logic [NW-1:0]    waddr,
  input  logic [NW-1:0]    ra_addr,
  input  logic [NW-1:0]    rb_addr,
  output logic [CNT_W-1:0] ra_data,
  output logic [CNT_W-1:0] rb_data
);

  logic [CNT_W-1:0] mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[waddr] <= wr.data;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

[design/differential_backlog_scheduler_core.sv]
`timescale 1ns / 1ps
// Top level of the differential backlog scheduler: cell ring, count table, control.
// Depends on dbs_pkg, dbs_if, dbs_cell, dbs_count_mem.
//
//  channel | dir | payload                                       | transfer when
//  req     | in  | action, packet_tag, dest_addr, hop_addr, hop_valid | valid & ready
//  rsp     | out | status, out_tag, out_dest, out_gap            | valid & ready
//  cfg     | in  | per_dest_limit                                | valid & ready
//
// From the req transfer to rsp.valid rising, a request passes these states:
// Enqueue: S_ENQ_RD, S_ENQ_DC, S_DONE. Empty dequeue: S_DONE.
// Dequeue: S_SCAN, S_DRAIN, S_REMOVE, S_DONE; the ring of cells rotates once past the
//   count table's two read ports, one entry per cycle.
// After reset the count table is cleared row by row, with req not ready;
//   cfg is ready throughout.
// One request at a time; a new request is taken while the last result waits.
module differential_backlog_scheduler_core import dbs_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int NODE_COUNT  = NODE_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  dbs_req_if.sink   req,
  dbs_rsp_if.source rsp,
  dbs_cfg_if.sink   cfg
);

  localparam int IW = $clog2(STORE_DEPTH);
  localparam int OW = $clog2(STORE_DEPTH + 1);
  localparam int NW = $clog2(NODE_COUNT);
  localparam int ADDR_N = 1 << ADDR_W;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_ENQ_RD = 8'b0000_0100,
    S_ENQ_DC = 8'b0000_1000,
    S_SCAN   = 8'b0001_0000,
    S_DRAIN  = 8'b0010_0000,
    S_REMOVE = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state;

  // Address to table row, worked out at elaboration.
  logic [NW-1:0] node_tab [ADDR_N];
  for (genvar a = 0; a < ADDR_N; a++) begin : g_tab
    assign node_tab[a] = NW'(a % NODE_COUNT);
  end

  logic [CNT_W-1:0] limit;
  logic [OW-1:0]    occ;
  logic [NW-1:0]    clr_addr;
  logic [IW-1:0]    step;
  entry_t           enq;

  // scan pipeline: entry whose counts are being read
  logic             p1_valid;
  logic [IW-1:0]    p1_idx;
  entry_t           p1;
  logic [NW-1:0]    p1_node;

  logic [IW-1:0]    best_idx;
  logic [CNT_W-1:0] best_gap;
  logic [CNT_W-1:0] best_cnt;
  logic [NW-1:0]    best_node;
  entry_t           best;

  status_t          res_status;
  logic [TAG_W-1:0] res_tag;
  logic [ADDR_W-1:0] res_dest;
  logic [CNT_W-1:0] res_gap;

  // ---- ring of cells; cell 0 is the oldest entry ----
  entry_t cells [STORE_DEPTH];
  logic   enq_write;
  logic   over_limit;

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    logic load_i;
    logic move_i;
    assign load_i = enq_write && (occ == OW'(i));
    // rotate during a scan; close the gap at the winner on removal
    assign move_i = (state == S_SCAN) ||
                    ((state == S_REMOVE) && (best_idx <= IW'(i)));
    dbs_cell u_cell (
      .clk        (clk),
      .load       (load_i),
      .move       (move_i),
      .load_entry (enq),
      .nbr_entry  (cells[(i + 1) % STORE_DEPTH]),
      .entry      (cells[i])
    );
  end

  // ---- count table ----
  cnt_wr_t          wr;
  logic [NW-1:0]    waddr;
  logic [NW-1:0]    ra_addr;
  logic [CNT_W-1:0] ra_data;
  logic [CNT_W-1:0] rb_data;

  dbs_count_mem #(.NODE_COUNT(NODE_COUNT), .NW(NW)) u_cnt (
    .clk     (clk),
    .wr      (wr),
    .waddr   (waddr),
    .ra_addr (ra_addr),
    .rb_addr (node_tab[cells[0].hop]),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  assign ra_addr = (state == S_SCAN) ? node_tab[cells[0].dest] : node_tab[enq.dest];

  // limit check against the count read for the arriving destination
  assign over_limit = ({1'b0, ra_data} + 8'd1) > {1'b0, limit};
  assign enq_write  = (state == S_ENQ_DC) && !over_limit && (occ != OW'(STORE_DEPTH));

  always_comb begin
    wr    = '0;
    waddr = clr_addr;
    case (state)
      S_CLEAR: begin
        wr.en = 1'b1;
      end
      S_ENQ_DC: begin
        wr.en   = enq_write;
        wr.data = ra_data + CNT_W'(1);
        waddr   = node_tab[enq.dest];
      end
      S_REMOVE: begin
        wr.en   = (best_cnt != '0);
        wr.data = best_cnt - CNT_W'(1);
        waddr   = best_node;
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  // gap of the entry in p1, counts just read
  logic [CNT_W-1:0] there;
  logic [CNT_W-1:0] gap;
  assign there = p1.hop_valid ? rb_data : '0;
  assign gap   = (ra_data >= there) ? (ra_data - there) : (there - ra_data);

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      occ       <= '0;
      limit     <= LIMIT_RESET;
      rsp.valid <= 1'b0;
      p1_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        limit <= cfg.per_dest_limit;
      end
      // S_DONE reloads the result register itself
      if (rsp.valid && rsp.ready && (state != S_DONE)) begin
        rsp.valid <= 1'b0;
      end

      // scan tail: compare the entry whose counts arrived
      if (p1_valid && ((p1_idx == '0) || (gap > best_gap))) begin
        best_idx  <= p1_idx;
        best_gap  <= gap;
        best_cnt  <= ra_data;
        best_node <= p1_node;
        best      <= p1;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + NW'(1);
          if (clr_addr == NW'(NODE_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          p1_valid <= 1'b0;
          if (req.valid) begin
            enq.tag       <= req.packet_tag;
            enq.dest      <= req.dest_addr;
            enq.hop       <= req.hop_addr;
            enq.hop_valid <= req.hop_valid;
            res_tag       <= '0;
            res_dest      <= '0;
            res_gap       <= '0;
            if (req.action == ACT_ENQUEUE) begin
              state <= S_ENQ_RD;
            end else if (occ == '0) begin
              res_status <= ST_EMPTY;
              state      <= S_DONE;
            end else begin
              step  <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_ENQ_RD: begin
          state <= S_ENQ_DC;
        end
        S_ENQ_DC: begin
          if (over_limit) begin
            res_status <= ST_OVER_LIMIT;
          end else if (occ == OW'(STORE_DEPTH)) begin
            res_status <= ST_STORE_FULL;
          end else begin
            res_status <= ST_ACCEPTED;
            occ        <= occ + OW'(1);
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          p1_valid <= ({1'b0, step} < occ);
          p1_idx   <= step;
          p1       <= cells[0];
          p1_node  <= node_tab[cells[0].dest];
          step     <= step + IW'(1);
          if (step == IW'(STORE_DEPTH - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          p1_valid <= 1'b0;
          state    <= S_REMOVE;
        end
        S_REMOVE: begin
          occ        <= occ - OW'(1);
          res_status <= ST_DEQUEUED;
          res_tag    <= best.tag;
          res_dest   <= best.dest;
          res_gap    <= best_gap;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid    <= 1'b1;
            rsp.status   <= res_status;
            rsp.out_tag  <= res_tag;
            rsp.out_dest <= res_dest;
            rsp.out_gap  <= res_gap;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/dbs_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the scheduler top, bound to it.
// Depends on dbs_pkg and differential_backlog_scheduler_core.
module dbs_checker import dbs_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] status,
  input logic [TAG_W-1:0]    out_tag,
  input logic [ADDR_W-1:0]   out_dest,
  input logic [CNT_W-1:0]    out_gap
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(out_tag))
    else $error("response dropped or changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == ST_ACCEPTED || status == ST_OVER_LIMIT ||
                   status == ST_STORE_FULL || status == ST_DEQUEUED || status == ST_EMPTY))
    else $error("bad status code");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_DEQUEUED |-> out_tag == '0 && out_dest == '0 && out_gap == '0)
    else $error("nonzero payload without a dequeue");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while one is in progress");

endmodule

bind differential_backlog_scheduler_core dbs_checker u_dbs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .out_tag   (rsp.out_tag),
  .out_dest  (rsp.out_dest),
  .out_gap   (rsp.out_gap)
);

[bench/tb_differential_backlog_scheduler_core.sv]
`timescale 1ns / 1ps
// Testbench of differential_backlog_scheduler_core: enqueue/dequeue scheduling by backlog gap.
// Depends on dbs_pkg, dbs_if and the design; holds its own scheduler predictor.
module tb_differential_backlog_scheduler_core;
  import dbs_pkg::*;

  localparam int DEPTH = STORE_DEPTH_DEF;
  localparam int NODES = NODE_COUNT_DEF;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    tag;
    logic [ADDR_W-1:0]   dest;
    logic [CNT_W-1:0]    gap;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  dbs_req_if req ();
  dbs_rsp_if rsp ();
  dbs_cfg_if cfg ();

  differential_backlog_scheduler_core u_dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  // Predictor state: the queued packets in arrival order and the count table.
  entry_t           sched_q[$];
  logic [CNT_W-1:0] node_backlog[NODES];
  logic [CNT_W-1:0] limit_now;
  outcome_t         pending_outcomes[$];

  int errors = 0;
  int idle_cycles = 0;
  bit done = 0;
  bit rsp_stall_off = 0;

  function automatic logic [CNT_W-1:0] backlog_gap(entry_t e);
    logic [CNT_W-1:0] here, there;
    here = node_backlog[e.dest];
    there = e.hop_valid ? node_backlog[e.hop] : '0;
    return (here >= there) ? here - there : there - here;
  endfunction

  // Computes the outcome of one request and advances the predictor.
  function automatic outcome_t schedule_step(logic act, entry_t pkt);
    outcome_t o;
    int best;
    logic [CNT_W-1:0] best_gap, g;
    o = '0;
    if (act == ACT_ENQUEUE) begin
      // limit check takes priority over store full
      if (int'(node_backlog[pkt.dest]) + 1 > int'(limit_now)) begin
        o.status = ST_OVER_LIMIT;
      end else if (sched_q.size() >= DEPTH) begin
        o.status = ST_STORE_FULL;
      end else begin
        sched_q.insert(sched_q.size(), pkt);
        node_backlog[pkt.dest]++;
        o.status = ST_ACCEPTED;
      end
    end else if (sched_q.size() == 0) begin
      o.status = ST_EMPTY;
    end else begin
      // oldest entry wins ties: strict greater-than
      best = 0;
      best_gap = backlog_gap(sched_q[0]);
      for (int i = 1; i < sched_q.size(); i++) begin
        g = backlog_gap(sched_q[i]);
        if (g > best_gap) begin
          best_gap = g;
          best = i;
        end
      end
      o.status = ST_DEQUEUED;
      o.tag = sched_q[best].tag;
      o.dest = sched_q[best].dest;
      o.gap = best_gap;
      if (node_backlog[sched_q[best].dest] > 0) node_backlog[sched_q[best].dest]--;
      sched_q.delete(best);
    end
    return o;
  endfunction

  // Initial drive values, all known from time zero.
  initial begin
    req.valid = 1'b0;
    req.action = ACT_ENQUEUE;
    req.packet_tag = '0;
    req.dest_addr = '0;
    req.hop_addr = '0;
    req.hop_valid = 1'b0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.per_dest_limit = '0;
  end

  // Response side: random stall per transfer, compare with oldest expectation.
  initial begin : rsp_sink
    int wait_n;
    outcome_t got, want;
    @(negedge clk);
    forever begin
      wait_n = rsp_stall_off ? 0 : $urandom_range(0, 12);
      if (wait_n > 0) begin
        rsp.ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      got = '{rsp.status, rsp.out_tag, rsp.out_dest, rsp.out_gap};
      if (pending_outcomes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p", got);
      end else begin
        want = pending_outcomes.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: status exp %0d got %0d, tag exp %h got %h, ",
                      "dest exp %h got %h, gap exp %0d got %0d"},
                     want.status, got.status, want.tag, got.tag,
                     want.dest, got.dest, want.gap, got.gap);
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog: cycles in which no transfer happens on any channel.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT && !done) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Send one request after a random gap; prediction made at the transfer.
  task automatic send_req(logic act, logic [TAG_W-1:0] tag, logic [ADDR_W-1:0] dest,
                          logic [ADDR_W-1:0] hop, logic hv, bit no_gap = 0);
    entry_t pkt;
    outcome_t o;
    int gap_n;
    gap_n = no_gap ? 0 : $urandom_range(0, 12);
    if (gap_n > 0) begin
      req.valid <= 1'b0;
      repeat (gap_n) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.action <= act;
    req.packet_tag <= tag;
    req.dest_addr <= dest;
    req.hop_addr <= hop;
    req.hop_valid <= hv;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pkt = '{tag, dest, hv, hop};
    o = schedule_step(act, pkt);
    pending_outcomes.insert(pending_outcomes.size(), o);
    @(negedge clk);
  endtask

  task automatic release_req();
    req.valid <= 1'b0;
  endtask

  // Wait until every result is back, then let the longest dequeue drain.
  task automatic drain();
    release_req();
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (DEPTH + 10) @(negedge clk);
  endtask

  task automatic write_limit(logic [CNT_W-1:0] value);
    drain();
    cfg.valid <= 1'b1;
    cfg.per_dest_limit <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    limit_now = value;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_random(int n, int dest_span, int deq_pct);
    logic [ADDR_W-1:0] d, h;
    for (int i = 0; i < n; i++) begin
      d = (dest_span >= 256) ? ADDR_W'($urandom_range(0, 255))
                             : ADDR_W'($urandom_range(0, dest_span - 1));
      h = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom_range(0, 255))
                                      : ADDR_W'($urandom_range(0, dest_span - 1));
      send_req($urandom_range(0, 99) < deq_pct, TAG_W'($urandom), d, h,
               1'($urandom_range(0, 1)));
    end
  endtask

  // Directed: empty dequeue, field extremes, ties, gap ordering, missing hop.
  task automatic test_directed();
    send_req(ACT_DEQUEUE, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
    send_req(ACT_ENQUEUE, 16'h0000, 8'h00, 8'h00, 1'b0);
    send_req(ACT_ENQUEUE, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
    send_req(ACT_ENQUEUE, 16'hA5A5, 8'hFF, 8'h00, 1'b1);
    send_req(ACT_ENQUEUE, 16'h5A5A, 8'h00, 8'hFF, 1'b1);
    send_req(ACT_ENQUEUE, 16'h1234, 8'h7F, 8'h80, 1'b0);
    repeat (6) send_req(ACT_DEQUEUE, TAG_W'($urandom), ADDR_W'($urandom),
                        ADDR_W'($urandom), 1'($urandom_range(0, 1)));
    // tie: equal gaps, oldest must win
    send_req(ACT_ENQUEUE, 16'h0101, 8'h10, 8'h11, 1'b1);
    send_req(ACT_ENQUEUE, 16'h0202, 8'h11, 8'h10, 1'b1);
    send_req(ACT_DEQUEUE, '0, '0, '0, 1'b0);
    send_req(ACT_DEQUEUE, '0, '0, '0, 1'b0);
  endtask

  // Limit of one and the largest limit; over-limit drops on a repeated destination.
  task automatic test_limit_extremes();
    write_limit(CNT_W'(1));
    send_req(ACT_ENQUEUE, 16'h0001, 8'h22, 8'h00, 1'b0);
    send_req(ACT_ENQUEUE, 16'h0002, 8'h22, 8'h00, 1'b0);
    send_random(60, 8, 30);
    write_limit(CNT_W'(0));
    send_random(20, 256, 50);
    write_limit(CNT_W'(64));
    // fill past the store depth on one destination: store full, not over limit
    for (int i = 0; i < DEPTH + 4; i++)
      send_req(ACT_ENQUEUE, TAG_W'($urandom), 8'h33, ADDR_W'($urandom), 1'b1);
    write_limit(CNT_W'(127));
    send_random(10, 256, 0);
    send_random(80, 4, 55);
  endtask

  // Random traffic at several limits and destination spans; the narrowest span lets gaps grow large.
  task automatic test_random_traffic();
    logic [CNT_W-1:0] lim[4] = '{CNT_W'(50), CNT_W'(3), CNT_W'(64), CNT_W'(17)};
    foreach (lim[k]) begin
      write_limit(lim[k]);
      send_random(100, 4, 45);
      send_random(60, 16, 40);
      send_random(40, 256, 45);
    end
  endtask

  // Back-to-back requests with the response side never stalling, then random traffic with stalls.
  task automatic test_back_to_back();
    rsp_stall_off = 1;
    for (int i = 0; i < 80; i++)
      send_req(1'($urandom_range(0, 1)), TAG_W'($urandom), ADDR_W'($urandom_range(0, 5)),
               ADDR_W'($urandom_range(0, 5)), 1'($urandom_range(0, 1)), 1'b1);
    release_req();
    while (pending_outcomes.size() != 0) @(negedge clk);
    rsp_stall_off = 0;
    send_random(60, 6, 50);
  endtask

  initial begin
    limit_now = LIMIT_RESET;
    foreach (node_backlog[i]) node_backlog[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_limit_extremes();
    test_random_traffic();
    test_back_to_back();
    drain();
    done = 1;
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
